// ===== sv/midi_track_event_parser_defines.svh =====
// Assertion macros shared by the track event parser modules.
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define MTEP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MTEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MTEP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MTEP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/mtep_pkg.sv =====
// Package with the types and constants of the track event parser.
`default_nettype none
package mtep_pkg;
  localparam int unsigned DivWidth = 24;
  localparam logic [25:0] TempoNumerator = 26'd60500000;

  localparam logic [3:0] PH_DELAY    = 4'd0;
  localparam logic [3:0] PH_STATUS   = 4'd1;
  localparam logic [3:0] PH_ARG1     = 4'd2;
  localparam logic [3:0] PH_ARG2     = 4'd3;
  localparam logic [3:0] PH_SKIP     = 4'd4;
  localparam logic [3:0] PH_SYX_LEN  = 4'd5;
  localparam logic [3:0] PH_META_TY  = 4'd6;
  localparam logic [3:0] PH_META_LEN = 4'd7;
  localparam logic [3:0] PH_TEMPO    = 4'd8;

  localparam logic [2:0] EV_NOTE_OFF = 3'd0;
  localparam logic [2:0] EV_NOTE_ON  = 3'd1;
  localparam logic [2:0] EV_VOLUME   = 3'd2;
  localparam logic [2:0] EV_PAN      = 3'd3;
  localparam logic [2:0] EV_BEND     = 3'd4;
  localparam logic [2:0] EV_TEMPO    = 3'd5;
  localparam logic [2:0] EV_EOT      = 3'd6;
  localparam logic [2:0] EV_META     = 3'd7;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_STATUS    = 3'd1;
  localparam logic [2:0] ERR_DELAY     = 3'd2;
  localparam logic [2:0] ERR_META_SIZE = 3'd3;
  localparam logic [2:0] ERR_TRUNC     = 3'd4;

  typedef struct packed {
    logic start;
    logic [DivWidth-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [15:0] bpm;
  } div_sts_t;
endpackage
`default_nettype wire

// ===== sv/mtep_if.sv =====
// Valid/ready channel interfaces for the parser.
`default_nettype none
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;
  modport source (output valid, data_byte, chunk_end, input ready);
  modport sink (input valid, data_byte, chunk_end, output ready);
endinterface

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [3:0]  channel;
  logic [31:0] delay_ticks;
  logic [15:0] first_arg;
  logic [7:0]  second_arg;
  logic [2:0]  error_code;
  modport source (output valid, event_kind, channel, delay_ticks, first_arg, second_arg,
                  error_code, input ready);
  modport sink (input valid, event_kind, channel, delay_ticks, first_arg, second_arg,
                error_code, output ready);
endinterface
`default_nettype wire

// ===== sv/midi_track_event_parser.sv =====
// A result is registered as its event's last byte is taken; a tempo's once divided.
// Throughput: one byte per cycle while the result register drains.
// A tempo event holds the input while the bit-serial tempo divider works.
// Reset (synchronous, active low) returns the parser to expecting a delay.
// Errors and end of track ignore bytes until the chunk's last byte.
`default_nettype none
module midi_track_event_parser (
  input wire logic   clk,
  input wire logic   rst_n,
  mtep_in_if.sink    in_ch,
  mtep_out_if.source out_ch
);
  mtep_pkg::div_cmd_t div_cmd;
  mtep_pkg::div_sts_t div_sts;

  mtep_parser u_parser (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .div_cmd(div_cmd), .div_sts(div_sts)
  );

  mtep_divider u_divider (
    .clk(clk), .rst_n(rst_n), .cmd(div_cmd), .sts(div_sts)
  );
endmodule
`default_nettype wire

// ===== sv/mtep_divider.sv =====
// Restoring divider computing the clamped tempo in beats per minute.
`default_nettype none
`include "midi_track_event_parser_defines.svh"
module mtep_divider (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mtep_pkg::div_cmd_t cmd,
  output mtep_pkg::div_sts_t    sts
);
  localparam int unsigned NumW = 26;
  localparam int unsigned RemW = mtep_pkg::DivWidth + 1;

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic [NumW-1:0] quo_r, quo_nxt;
  logic [RemW-1:0] rem_r, rem_nxt;
  logic [mtep_pkg::DivWidth-1:0] dvs_r, dvs_nxt;
  logic [RemW-1:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r[RemW-2:0], quo_r[NumW-1]};
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(NumW);
      quo_nxt  = mtep_pkg::TempoNumerator;
      rem_nxt  = '0;
      dvs_nxt  = cmd.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  // A zero divisor yields an all-ones quotient, which also clamps.
  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.bpm  = (quo_r[NumW-1:16] != '0) ? 16'hFFFF : quo_r[15:0];

  `MTEP_ASSERT_NEXT(a_div_done, clk, rst_n, busy_r && cnt_r == 5'd1 && !cmd.start, done_r)
  `MTEP_ASSERT_IMP(a_div_excl, clk, rst_n, done_r, !busy_r)
  `MTEP_ASSERT_IMP(a_div_start, clk, rst_n, cmd.start, !busy_r)
endmodule
`default_nettype wire

// ===== sv/mtep_parser.sv =====
// Byte parser state machine with its field registers and result register.
`default_nettype none
`include "midi_track_event_parser_defines.svh"
module mtep_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  mtep_in_if.sink                in_ch,
  mtep_out_if.source             out_ch,
  output mtep_pkg::div_cmd_t     div_cmd,
  input  wire mtep_pkg::div_sts_t div_sts
);
  logic [3:0]  phase_r, phase_nxt;
  logic [31:0] vlq_r, vlq_nxt;
  logic [2:0]  vcnt_r, vcnt_nxt;
  logic [31:0] delay_r, delay_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  mtype_r, mtype_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [23:0] pay_r, pay_nxt;
  logic [1:0]  pidx_r, pidx_nxt;
  logic        halt_r, halt_nxt;
  logic        wait_r, wait_nxt;
  logic [31:0] wdelay_r, wdelay_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  okind_r, okind_nxt;
  logic [3:0]  och_r, och_nxt;
  logic [31:0] odly_r, odly_nxt;
  logic [15:0] oa1_r, oa1_nxt;
  logic [7:0]  oa2_r, oa2_nxt;
  logic [2:0]  oerr_r, oerr_nxt;

  logic        acc, res, vlq_done, vlq_err, is_meta_unh;
  logic [31:0] vlq_val;
  logic [7:0]  b;
  logic [3:0]  hi;
  logic [31:0] skip_dec;

  assign b            = in_ch.data_byte;
  assign hi           = status_r[7:4];
  assign in_ch.ready  = !wait_r && !(ov_r && !out_ch.ready);
  assign acc          = in_ch.valid && in_ch.ready;
  assign vlq_err      = vcnt_r >= 3'd5;
  assign vlq_val      = {vlq_r[24:0], b[6:0]};
  assign vlq_done     = !vlq_err && !b[7];
  assign is_meta_unh  = status_r == 8'hFF && mtype_r != 8'h03;
  assign skip_dec     = skip_r - 32'd1;

  always_comb begin
    phase_nxt = phase_r; vlq_nxt = vlq_r; vcnt_nxt = vcnt_r; delay_nxt = delay_r;
    status_nxt = status_r; mtype_nxt = mtype_r; skip_nxt = skip_r; pay_nxt = pay_r;
    pidx_nxt = pidx_r; halt_nxt = halt_r; wait_nxt = wait_r; wdelay_nxt = wdelay_r;
    ov_nxt = ov_r && !out_ch.ready;
    okind_nxt = okind_r; och_nxt = och_r; odly_nxt = odly_r;
    oa1_nxt = oa1_r; oa2_nxt = oa2_r; oerr_nxt = oerr_r;
    res = 1'b0;
    div_cmd.start = 1'b0;
    div_cmd.divisor = pay_r;
    if (div_sts.done) begin
      ov_nxt = 1'b1; okind_nxt = mtep_pkg::EV_TEMPO; och_nxt = '0;
      odly_nxt = wdelay_r; oa1_nxt = div_sts.bpm; oa2_nxt = '0;
      oerr_nxt = mtep_pkg::ERR_NONE; wait_nxt = 1'b0;
    end
    if (acc) begin
      if (!halt_r) begin
        case (phase_r)
          mtep_pkg::PH_DELAY, mtep_pkg::PH_SYX_LEN, mtep_pkg::PH_META_LEN: begin
            if (vlq_err) begin
              res = 1'b1; halt_nxt = 1'b1;
              okind_nxt = '0; och_nxt = '0; odly_nxt = '0; oa1_nxt = '0; oa2_nxt = '0;
              oerr_nxt = mtep_pkg::ERR_DELAY;
            end else begin
              vlq_nxt = vlq_val; vcnt_nxt = vcnt_r + 3'd1;
              if (vlq_done) begin
                vlq_nxt = '0; vcnt_nxt = '0;
                if (phase_r == mtep_pkg::PH_DELAY) begin
                  delay_nxt = vlq_val; phase_nxt = mtep_pkg::PH_STATUS;
                end else if (phase_r == mtep_pkg::PH_META_LEN && mtype_r == 8'h2F) begin
                  res = 1'b1; halt_nxt = 1'b1;
                  okind_nxt = '0; och_nxt = '0; odly_nxt = '0; oa1_nxt = '0; oa2_nxt = '0;
                  if (vlq_val != '0) begin
                    oerr_nxt = mtep_pkg::ERR_META_SIZE;
                  end else begin
                    okind_nxt = mtep_pkg::EV_EOT; odly_nxt = delay_r;
                    oerr_nxt = mtep_pkg::ERR_NONE;
                  end
                end else if (phase_r == mtep_pkg::PH_META_LEN && mtype_r == 8'h51) begin
                  if (vlq_val != 32'd3) begin
                    res = 1'b1; halt_nxt = 1'b1;
                    okind_nxt = '0; och_nxt = '0; odly_nxt = '0; oa1_nxt = '0;
                    oa2_nxt = '0; oerr_nxt = mtep_pkg::ERR_META_SIZE;
                  end else begin
                    pay_nxt = '0; pidx_nxt = '0; phase_nxt = mtep_pkg::PH_TEMPO;
                  end
                end else begin
                  skip_nxt = vlq_val;
                  if (vlq_val == '0) begin
                    phase_nxt = mtep_pkg::PH_DELAY;
                    if (is_meta_unh) begin
                      res = 1'b1; okind_nxt = mtep_pkg::EV_META; och_nxt = '0;
                      odly_nxt = delay_r; oa1_nxt = '0; oa2_nxt = '0;
                      oerr_nxt = mtep_pkg::ERR_NONE;
                    end
                  end else begin
                    phase_nxt = mtep_pkg::PH_SKIP;
                  end
                end
              end
            end
          end
          mtep_pkg::PH_STATUS: begin
            status_nxt = b; pidx_nxt = '0; pay_nxt = '0;
            if (b[7:4] == 4'h8 || b[7:4] == 4'h9 || b[7:4] == 4'hB || b[7:4] == 4'hE) begin
              phase_nxt = mtep_pkg::PH_ARG1;
            end else if (b[7:4] == 4'hA) begin
              skip_nxt = 32'd2; phase_nxt = mtep_pkg::PH_SKIP;
            end else if (b[7:4] == 4'hC || b[7:4] == 4'hD) begin
              skip_nxt = 32'd1; phase_nxt = mtep_pkg::PH_SKIP;
            end else if (b == 8'hF0 || b == 8'hF7) begin
              phase_nxt = mtep_pkg::PH_SYX_LEN;
            end else if (b == 8'hFF) begin
              phase_nxt = mtep_pkg::PH_META_TY;
            end else begin
              res = 1'b1; halt_nxt = 1'b1;
              okind_nxt = '0; och_nxt = '0; odly_nxt = '0; oa1_nxt = '0; oa2_nxt = '0;
              oerr_nxt = mtep_pkg::ERR_STATUS;
            end
          end
          mtep_pkg::PH_ARG1: begin
            pay_nxt = {16'd0, b}; phase_nxt = mtep_pkg::PH_ARG2;
          end
          mtep_pkg::PH_ARG2: begin
            phase_nxt = mtep_pkg::PH_DELAY;
            och_nxt = status_r[3:0]; odly_nxt = delay_r; oa2_nxt = '0;
            oerr_nxt = mtep_pkg::ERR_NONE;
            if (hi == 4'h8 || hi == 4'h9) begin
              res = 1'b1;
              okind_nxt = (hi == 4'h8) ? mtep_pkg::EV_NOTE_OFF : mtep_pkg::EV_NOTE_ON;
              oa1_nxt = {8'd0, pay_r[7:0]}; oa2_nxt = b;
            end else if (hi == 4'hE) begin
              res = 1'b1; okind_nxt = mtep_pkg::EV_BEND;
              oa1_nxt = {2'd0, b[6:0], pay_r[6:0]};
            end else if (pay_r[7:0] == 8'h07 || pay_r[7:0] == 8'h0A) begin
              res = 1'b1;
              okind_nxt = (pay_r[7:0] == 8'h07) ? mtep_pkg::EV_VOLUME : mtep_pkg::EV_PAN;
              oa1_nxt = {8'd0, b};
            end
          end
          mtep_pkg::PH_SKIP: begin
            skip_nxt = skip_dec;
            if (skip_dec == '0) begin
              phase_nxt = mtep_pkg::PH_DELAY;
              if (is_meta_unh) begin
                res = 1'b1; okind_nxt = mtep_pkg::EV_META; och_nxt = '0;
                odly_nxt = delay_r; oa1_nxt = '0; oa2_nxt = '0;
                oerr_nxt = mtep_pkg::ERR_NONE;
              end
            end
          end
          mtep_pkg::PH_META_TY: begin
            mtype_nxt = b; phase_nxt = mtep_pkg::PH_META_LEN;
          end
          mtep_pkg::PH_TEMPO: begin
            pay_nxt = {pay_r[15:0], b}; pidx_nxt = pidx_r + 2'd1;
            if (pidx_r == 2'd2) begin
              phase_nxt = mtep_pkg::PH_DELAY;
              // The tempo request finishes once the divider is done.
              div_cmd.start = 1'b1; div_cmd.divisor = {pay_r[15:0], b};
              wait_nxt = 1'b1; wdelay_nxt = delay_r;
              res = 1'b1;
            end
          end
          default: phase_nxt = mtep_pkg::PH_DELAY;
        endcase
      end
      if (in_ch.chunk_end) begin
        if (!halt_nxt && !res && !(phase_nxt == mtep_pkg::PH_DELAY && vcnt_nxt == '0)) begin
          res = 1'b1;
          okind_nxt = '0; och_nxt = '0; odly_nxt = '0; oa1_nxt = '0; oa2_nxt = '0;
          oerr_nxt = mtep_pkg::ERR_TRUNC;
        end
        phase_nxt = mtep_pkg::PH_DELAY; vlq_nxt = '0; vcnt_nxt = '0; delay_nxt = '0;
        status_nxt = '0; mtype_nxt = '0; skip_nxt = '0; pay_nxt = '0; pidx_nxt = '0;
        halt_nxt = 1'b0;
      end
      if (res && !div_cmd.start) ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mtep_pkg::PH_DELAY; vlq_r <= '0; vcnt_r <= '0; delay_r <= '0;
      status_r <= '0; mtype_r <= '0; skip_r <= '0; pay_r <= '0; pidx_r <= '0;
      halt_r <= 1'b0; wait_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; vlq_r <= vlq_nxt; vcnt_r <= vcnt_nxt; delay_r <= delay_nxt;
      status_r <= status_nxt; mtype_r <= mtype_nxt; skip_r <= skip_nxt; pay_r <= pay_nxt;
      pidx_r <= pidx_nxt; halt_r <= halt_nxt; wait_r <= wait_nxt; ov_r <= ov_nxt;
    end
    wdelay_r <= wdelay_nxt;
    okind_r <= okind_nxt; och_r <= och_nxt; odly_r <= odly_nxt;
    oa1_r <= oa1_nxt; oa2_r <= oa2_nxt; oerr_r <= oerr_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.event_kind  = okind_r;
  assign out_ch.channel     = och_r;
  assign out_ch.delay_ticks = odly_r;
  assign out_ch.first_arg   = oa1_r;
  assign out_ch.second_arg  = oa2_r;
  assign out_ch.error_code  = oerr_r;

  `MTEP_ASSERT_IMP(a_wait_div, clk, rst_n, wait_r && !div_sts.done, div_sts.busy)
  `MTEP_ASSERT_IMP(a_done_free, clk, rst_n, div_sts.done, !ov_r)
  `MTEP_ASSERT_NEXT(a_start_wait, clk, rst_n, div_cmd.start, wait_r)
endmodule
`default_nettype wire
